// File: rtl/core/siad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siad_pkg
// Shared constants and types for the signed integer to decimal text unit.
// ----------------------------------------------------------------------------
package siad_pkg;

	localparam int VALUE_BITS = 32;

	// Decimal digits of 2^(VALUE_BITS-1), the largest magnitude; 1233/4096 ~ log10(2).
	localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
	localparam int BCD_W      = NUM_DIGITS * 4;
	localparam int IDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int CNT_W      = $clog2(VALUE_BITS);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_DIGIT
	} siad_state_t;

endpackage

// File: rtl/core/siad_bcd_conv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siad_bcd_conv
// Shift-and-add-3 binary to BCD converter, one input bit per cycle.
// ----------------------------------------------------------------------------
module siad_bcd_conv import siad_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] mag,
	output logic                  done,
	output logic [BCD_W-1:0]      bcd
);

	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [BCD_W-1:0]      bcd_adj;

	// Every nibble of 5 or more gets 3 added so that the next shift carries correctly.
	always_comb begin
		for (int k = 0; k < NUM_DIGITS; k++) begin
			if (bcd_q[k*4 +: 4] >= 4'd5) begin
				bcd_adj[k*4 +: 4] = bcd_q[k*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[k*4 +: 4] = bcd_q[k*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			{bcd_q, bin_q} <= {bcd_adj[BCD_W-2:0], bin_q, 1'b0};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

// File: rtl/core/signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts a signed integer to its decimal ASCII text, one character per
// output transaction, most significant first, with the last one flagged.
// ----------------------------------------------------------------------------
// After an input is accepted, the BCD converter runs before the first character is offered.
// The BCD converter takes one input bit per cycle, so it sets most of that wait.
// Then one character per cycle without stall.
// One item at a time; in_stall stays high until the last character is taken.
// Reset returns the sequencer to idle; data registers are not cleared.
module signed_int_to_decimal_ascii_unit import siad_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   character,
	output logic                         last
);

	siad_state_t           state_q;
	siad_state_t           state_d;
	logic                  neg_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      msd;
	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag;
	logic                  in_acc;
	logic                  out_acc;
	logic                  conv_done;
	logic [BCD_W-1:0]      bcd;

	assign raw     = value;
	assign mag     = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	siad_bcd_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.mag    (mag),
		.done   (conv_done),
		.bcd    (bcd)
	);

	// Highest nonzero digit; a zero value leaves the ones digit.
	always_comb begin
		msd = '0;
		for (int k = 0; k < NUM_DIGITS; k++) begin
			if (bcd[k*4 +: 4] != 4'd0) begin
				msd = IDX_W'(k);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (conv_done) state_d = neg_q ? ST_SIGN : ST_DIGIT;
			end
			ST_SIGN: begin
				if (out_acc) state_d = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (out_acc && idx_q == '0) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		out_valid = (state_q == ST_SIGN) || (state_q == ST_DIGIT);
		last      = (state_q == ST_DIGIT) && (idx_q == '0);
		if (state_q == ST_SIGN) begin
			character = CHAR_MINUS;
		end else begin
			character = CHAR_ZERO | {4'h0, bcd[idx_q*4 +: 4]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			neg_q <= raw[VALUE_BITS-1];
		end
		if (state_q == ST_CONV && conv_done) begin
			idx_q <= msd;
		end else if (state_q == ST_DIGIT && out_acc && idx_q != '0) begin
			idx_q <= idx_q - 1'b1;
		end
	end

endmodule
